// ===== hw/rtl/bde_pkg.sv =====
// bde_pkg: shared types and constants of the bounded deque engine
// request and status codes, cell command struct and field widths
// depends on nothing; imported by every other file of the block
`default_nettype none

package bde_pkg;

	// fixed field widths of the request and response transactions
	localparam int VALUE_W     = 32;
	localparam int REQ_W       = 4;
	localparam int POS_W       = 5;
	localparam int STAT_W      = 3;
	localparam int COUNT_W     = 5;
	localparam int CAP_W       = 5;
	localparam int DEPTH_DEF   = 16;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK  = 4'd0,
		REQ_PUSH_FRONT = 4'd1,
		REQ_POP_BACK   = 4'd2,
		REQ_POP_FRONT  = 4'd3,
		REQ_REMOVE     = 4'd4,
		REQ_CLEAR      = 4'd5,
		REQ_FRONT      = 4'd6,
		REQ_BACK       = 4'd7,
		REQ_AT         = 4'd8,
		REQ_REVERSE    = 4'd9
	} req_code_t;

	// response status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_NULL      = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_EMPTY     = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_t;

	// command broadcast along the row of cells
	typedef enum logic [2:0] {
		CM_HOLD       = 3'd0,
		CM_WRITE      = 3'd1,
		CM_SHIFT_UP   = 3'd2,
		CM_SHIFT_DOWN = 3'd3,
		CM_REMOVE     = 3'd4,
		CM_MATCH      = 3'd5
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic               flip;
		logic               found_any;
		logic [VALUE_W-1:0] wdata;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bde_if.sv =====
// bde_if: request and response channel interfaces of the deque engine
// valid/ready handshake with the transaction payload alongside
// depends on bde_pkg
`default_nettype none

interface bde_req_if import bde_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [VALUE_W-1:0] item_value;
	logic [POS_W-1:0]   position;

	modport source (output valid, output req_type, output item_value, output position,
		input ready);
	modport sink (input valid, input req_type, input item_value, input position,
		output ready);
endinterface

interface bde_rsp_if import bde_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [VALUE_W-1:0] read_value;
	logic [COUNT_W-1:0] entry_count;

	modport source (output valid, output status, output read_value, output entry_count,
		input ready);
	modport sink (input valid, input status, input read_value, input entry_count,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bde_cell.sv =====
// bde_cell: one storage cell of the deque row
// holds one entry, shifts to either neighbour, flags a value match
// depends on bde_pkg
`default_nettype none

module bde_cell import bde_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int INDEX = 0,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cell_ctl_t          ctl,
	input  wire logic [CNT_W-1:0]   cnt,
	input  wire logic [VALUE_W-1:0] left_data,
	input  wire logic [VALUE_W-1:0] right_data,
	input  wire logic               hit_lo_in,
	input  wire logic               hit_hi_in,
	output logic [VALUE_W-1:0]      data,
	output logic                    hit_lo_out,
	output logic                    hit_hi_out
);

	logic [VALUE_W-1:0] data_q;
	logic               match_q;
	logic               occupied;
	logic               shift_rm;

	assign occupied = (CNT_W'(INDEX) < cnt);

	// match flags ripple from both ends of the row
	assign hit_lo_out = hit_lo_in | match_q;
	assign hit_hi_out = hit_hi_in | match_q;

	// normal order: first match from the bottom and all above it close the gap
	// flipped order: last match from the bottom and all above it close the gap
	assign shift_rm = ctl.flip ? (ctl.found_any & ~hit_hi_in) : (hit_lo_in | match_q);

	// match flag, computed in the search cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.mode == CM_MATCH) begin
			match_q <= occupied && (data_q == ctl.wdata);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			CM_WRITE: begin
				if (cnt == CNT_W'(INDEX))
					data_q <= ctl.wdata;
			end
			CM_SHIFT_UP:   data_q <= left_data;
			CM_SHIFT_DOWN: data_q <= right_data;
			CM_REMOVE: begin
				if (shift_rm)
					data_q <= right_data;
			end
			default: data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_deque_engine_unit.sv =====
// bounded_deque_engine_unit: bounded double-ended queue of nonzero values
// top level; a row of bde_cell instances holds the entries in order
// depends on bde_pkg, bde_if and bde_cell
//
// Usage: requests arrive on the req channel (valid/ready); each accepted
// transaction gives exactly one transaction on the rsp channel with a status,
// the value read (front, back, at) and the entry count afterwards. The
// capacity limit is written through cfg_we/cfg_data while the block is idle,
// which the user must keep to, as the block does not enforce it; zero or a
// value above DEPTH means the full depth. A request is taken in the idle
// state and executed in the exec state, and no new one is taken until it
// has executed. Remove first passes a match state, in which every cell
// compares its entry with the value at once; the chosen match and all cells
// above it shift to close the gap. Reverse only flips the walking direction.
// The response sits in an output register; while the receiver stalls a
// finished result waits there and the next request is still accepted, but it
// is not executed until the register is free.
// Reset empties the queue, clears the order flag and sets the limit to zero.
`default_nettype none

module bounded_deque_engine_unit import bde_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_data,
	bde_req_if.sink               req,
	bde_rsp_if.source             rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	typedef enum logic [1:0] {S_IDLE, S_MATCH, S_EXEC} state_t;

	state_t             state_q;
	logic [CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               flip_q;
	logic [REQ_W-1:0]   req_type_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [POS_W-1:0]   pos_s1;
	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [VALUE_W-1:0] rsp_value_q;
	logic [COUNT_W-1:0] rsp_count_q;

	cell_ctl_t          ctl;
	logic [VALUE_W-1:0] cell_data [DEPTH];
	logic [DEPTH:0]     hit_lo_c;
	logic [DEPTH:0]     hit_hi_c;
	logic               found_any;

	logic               go;
	logic               val_zero;
	logic               is_empty;
	logic               is_full;
	logic [LIM_W-1:0]   limit;
	logic [CNT_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   lpos;
	logic [IDX_W-1:0]   ppos;
	logic [VALUE_W-1:0] rd_data;
	status_t            status_nx;
	logic [VALUE_W-1:0] value_nx;
	logic [CNT_W-1:0]   cnt_nx;
	logic               flip_nx;
	cell_mode_t         mode_ex;

	// capacity limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	// row of cells
	assign hit_lo_c[0]     = 1'b0;
	assign hit_hi_c[DEPTH] = 1'b0;
	assign found_any       = hit_hi_c[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_W-1:0] left_d;
		logic [VALUE_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = ctl.wdata;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner
			assign right_d = cell_data[i+1];
		end

		bde_cell #(
			.DEPTH (DEPTH),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cnt        (cnt_q),
			.left_data  (left_d),
			.right_data (right_d),
			.hit_lo_in  (hit_lo_c[i]),
			.hit_hi_in  (hit_hi_c[i+1]),
			.data       (cell_data[i]),
			.hit_lo_out (hit_lo_c[i+1]),
			.hit_hi_out (hit_hi_c[i])
		);
	end

	// request decode and condition flags
	assign go       = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);
	assign val_zero = (value_s1 == '0);
	assign is_empty = (cnt_q == '0);
	assign limit    = ((cap_q == '0) || (LIM_W'(cap_q) > LIM_W'(DEPTH))) ?
		LIM_W'(DEPTH) : LIM_W'(cap_q);
	assign is_full  = (LIM_W'(cnt_q) >= limit);
	assign cnt_m1   = cnt_q - 1'b1;

	// logical position to cell index, then read
	always_comb begin
		case (req_code_t'(req_type_s1))
			REQ_FRONT: lpos = '0;
			REQ_BACK:  lpos = IDX_W'(cnt_m1);
			default:   lpos = IDX_W'(pos_s1);
		endcase
		ppos    = flip_q ? IDX_W'(cnt_m1 - CNT_W'(lpos)) : lpos;
		rd_data = cell_data[ppos];
	end

	// execution: status, result and next state of count and order
	always_comb begin
		status_nx = STAT_OK;
		value_nx  = '0;
		cnt_nx    = cnt_q;
		flip_nx   = flip_q;
		mode_ex   = CM_HOLD;
		case (req_code_t'(req_type_s1))
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (val_zero) begin
					status_nx = STAT_NULL;
				end else if (is_full) begin
					status_nx = STAT_FULL;
				end else begin
					cnt_nx = cnt_q + 1'b1;
					if ((req_code_t'(req_type_s1) == REQ_PUSH_BACK) ^ flip_q)
						mode_ex = CM_WRITE;
					else
						mode_ex = CM_SHIFT_UP;
				end
			end
			REQ_POP_BACK, REQ_POP_FRONT: begin
				if (is_empty) begin
					status_nx = STAT_EMPTY;
				end else begin
					cnt_nx = cnt_m1;
					if ((req_code_t'(req_type_s1) == REQ_POP_FRONT) ^ flip_q)
						mode_ex = CM_SHIFT_DOWN;
				end
			end
			REQ_REMOVE: begin
				if (val_zero) begin
					status_nx = STAT_NULL;
				end else if (!found_any) begin
					status_nx = STAT_NOT_FOUND;
				end else begin
					cnt_nx  = cnt_m1;
					mode_ex = CM_REMOVE;
				end
			end
			REQ_CLEAR: begin
				cnt_nx  = '0;
				flip_nx = 1'b0;
			end
			REQ_FRONT, REQ_BACK: begin
				if (is_empty)
					status_nx = STAT_EMPTY;
				else
					value_nx = rd_data;
			end
			REQ_AT: begin
				if (is_empty)
					status_nx = STAT_EMPTY;
				else if (LIM_W'(pos_s1) >= LIM_W'(cnt_q))
					status_nx = STAT_NOT_FOUND;
				else
					value_nx = rd_data;
			end
			REQ_REVERSE: begin
				if (cnt_q >= CNT_W'(2))
					flip_nx = ~flip_q;
			end
			default: ;
		endcase
	end

	// command to the cells
	always_comb begin
		ctl.wdata     = value_s1;
		ctl.flip      = flip_q;
		ctl.found_any = found_any;
		if (state_q == S_MATCH)
			ctl.mode = CM_MATCH;
		else if (go)
			ctl.mode = mode_ex;
		else
			ctl.mode = CM_HOLD;
	end

	// sequencer with request capture and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			flip_q       <= 1'b0;
			req_type_s1  <= '0;
			value_s1     <= '0;
			pos_s1       <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= STAT_OK;
			rsp_value_q  <= '0;
			rsp_count_q  <= '0;
		end else begin
			if (go)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_type_s1 <= req.req_type;
						value_s1    <= req.item_value;
						pos_s1      <= req.position;
						state_q     <= (req_code_t'(req.req_type) == REQ_REMOVE) ?
							S_MATCH : S_EXEC;
					end
				end
				S_MATCH: state_q <= S_EXEC;
				S_EXEC: begin
					if (go) begin
						cnt_q        <= cnt_nx;
						flip_q       <= flip_nx;
						rsp_status_q <= status_nx;
						rsp_value_q  <= value_nx;
						rsp_count_q  <= COUNT_W'(cnt_nx);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.read_value  = rsp_value_q;
	assign rsp.entry_count = rsp_count_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_chains_agree: assert property (@(posedge clk) disable iff (!arst_n)
		hit_lo_c[DEPTH] == hit_hi_c[0])
		else $error("match chains disagree");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while one is in progress");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == STAT_EMPTY) |-> (rsp.entry_count == '0))
		else $error("empty status with nonzero count");

endmodule

`default_nettype wire

// ===== test/bounded_deque_engine_unit_tb.sv =====
// bounded_deque_engine_unit_tb: self-checking testbench of the bounded deque engine
// predicts every response from a queue model of the entries and checks each one in order
// depends on bde_pkg, bde_if and bounded_deque_engine_unit
`default_nettype none

module bounded_deque_engine_unit_tb;
	import bde_pkg::*;

	// request codes with no operation behind them
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 4'd10;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'd15;
	localparam logic [VALUE_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0] entry_count;
	} deque_rsp_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_data;

	bde_req_if req_bus ();
	bde_rsp_if rsp_bus ();

	bounded_deque_engine_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_bus),
		.rsp      (rsp_bus)
	);

	// model state: entries from front to back, and the capacity register
	logic [VALUE_W-1:0] model_entries[$];
	logic [CAP_W-1:0]   cap_limit;
	deque_rsp_t         expected_responses[$];
	int                 mismatch_count;
	bit                 full_rate;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// works out the response of one request and updates the model
	function automatic deque_rsp_t predict_response(input logic [REQ_W-1:0] code,
		input logic [VALUE_W-1:0] value, input logic [POS_W-1:0] pos);
		deque_rsp_t         r;
		int                 limit;
		int                 hit;
		logic [VALUE_W-1:0] flipped[$];
		r.status = STAT_OK;
		r.read_value = '0;
		limit = (cap_limit == 0 || cap_limit > DEPTH_DEF) ? DEPTH_DEF : int'(cap_limit);
		case (code)
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (value == '0)
					r.status = STAT_NULL;
				else if (model_entries.size() >= limit)
					r.status = STAT_FULL;
				else if (code == REQ_PUSH_BACK)
					model_entries.push_back(value);
				else
					model_entries.push_front(value);
			end
			REQ_POP_BACK, REQ_POP_FRONT: begin
				if (model_entries.size() == 0)
					r.status = STAT_EMPTY;
				else if (code == REQ_POP_BACK)
					void'(model_entries.pop_back());
				else
					void'(model_entries.pop_front());
			end
			REQ_REMOVE: begin
				if (value == '0) begin
					r.status = STAT_NULL;
				end else begin
					// first matching entry goes, the rest close up
					hit = -1;
					for (int i = 0; i < model_entries.size(); i++)
						if (hit < 0 && model_entries[i] == value)
							hit = i;
					if (hit >= 0)
						model_entries.delete(hit);
					else
						r.status = STAT_NOT_FOUND;
				end
			end
			REQ_CLEAR: begin
				model_entries.delete();
			end
			REQ_FRONT, REQ_BACK: begin
				if (model_entries.size() == 0)
					r.status = STAT_EMPTY;
				else if (code == REQ_FRONT)
					r.read_value = model_entries[0];
				else
					r.read_value = model_entries[model_entries.size() - 1];
			end
			REQ_AT: begin
				if (model_entries.size() == 0)
					r.status = STAT_EMPTY;
				else if (pos >= model_entries.size())
					r.status = STAT_NOT_FOUND;
				else
					r.read_value = model_entries[pos];
			end
			REQ_REVERSE: begin
				if (model_entries.size() >= 2) begin
					foreach (model_entries[i])
						flipped.push_front(model_entries[i]);
					model_entries = flipped;
				end
			end
			default: begin
			end
		endcase
		r.entry_count = COUNT_W'(model_entries.size());
		return r;
	endfunction

	// mostly small values so that removes find duplicates, some zeros and wide values
	function automatic logic [VALUE_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return '0;
		if (roll < 8)
			return ALL_ONES;
		if (roll < 60)
			return $urandom_range(1, 12);
		return $urandom;
	endfunction

	// drives one request transaction and records its expected response
	task automatic send_request(input logic [REQ_W-1:0] code, input logic [VALUE_W-1:0] value,
		input logic [POS_W-1:0] pos);
		int gap;
		gap = full_rate ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.req_type <= code;
		req_bus.item_value <= value;
		req_bus.position <= pos;
		do @(posedge clk); while (!req_bus.ready);
		expected_responses.push_back(predict_response(code, value, pos));
	endtask

	// stops sending and waits until every response is back
	task automatic drain_pipeline();
		req_bus.valid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] limit);
		drain_pipeline();
		cfg_we <= 1'b1;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_limit = limit;
	endtask

	task automatic log_mismatch(input string what, input deque_rsp_t want, input deque_rsp_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: expected status %0d value %h count %0d, got status %0d value %h count %0d",
				what, want.status, want.read_value, want.entry_count,
				got.status, got.read_value, got.entry_count);
	endtask

	// compares one response transaction with the oldest expectation
	task automatic check_response();
		deque_rsp_t got;
		deque_rsp_t want;
		got.status = status_t'(rsp_bus.status);
		got.read_value = rsp_bus.read_value;
		got.entry_count = rsp_bus.entry_count;
		if (expected_responses.size() == 0) begin
			want = '0;
			log_mismatch("response with nothing outstanding", want, got);
		end else begin
			want = expected_responses.pop_front();
			if (got.status != want.status || got.read_value != want.read_value ||
				got.entry_count != want.entry_count)
				log_mismatch("response mismatch", want, got);
		end
	endtask

	// response side: random stalls, one check per transaction
	initial begin
		int stall;
		rsp_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = full_rate ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
			check_response();
		end
	end

	// every request kind on an empty deque
	task automatic test_empty_requests();
		send_request(REQ_POP_BACK, 32'd7, '0);
		send_request(REQ_POP_FRONT, 32'd7, '0);
		send_request(REQ_FRONT, '0, '0);
		send_request(REQ_BACK, '0, '0);
		send_request(REQ_AT, '0, '0);
		send_request(REQ_REMOVE, 32'd5, '0);
		send_request(REQ_REMOVE, '0, '0);
		send_request(REQ_PUSH_BACK, '0, '0);
		send_request(REQ_PUSH_FRONT, '0, '0);
		send_request(REQ_REVERSE, '0, '0);
		send_request(REQ_CLEAR, '0, '0);
		send_request(REQ_UNUSED_HI, ALL_ONES, '1);
	endtask

	// each operation on a few entries, value extremes, out of range read
	task automatic test_basic_ops();
		send_request(REQ_PUSH_BACK, ALL_ONES, '0);
		send_request(REQ_PUSH_FRONT, 32'd1, '0);
		send_request(REQ_REVERSE, '0, '0);
		send_request(REQ_FRONT, '0, '0);
		send_request(REQ_BACK, '0, '0);
		send_request(REQ_PUSH_BACK, 32'h8000_0000, '0);
		send_request(REQ_PUSH_FRONT, 32'h5555_5555, '0);
		send_request(REQ_AT, '0, 5'd3);
		send_request(REQ_AT, '0, '1);
		send_request(REQ_REMOVE, 32'd1, '0);
		send_request(REQ_REMOVE, 32'h0000_1234, '0);
		send_request(REQ_POP_FRONT, '0, '0);
		send_request(REQ_POP_BACK, '0, '0);
		send_request(REQ_REVERSE, '0, '0);
		send_request(REQ_UNUSED_LO, 32'hAAAA_AAAA, 5'd10);
		send_request(REQ_CLEAR, '0, '0);
	endtask

	// fill to depth, then lower the limit below the count
	task automatic test_limit_below_count();
		write_capacity('0);
		repeat (DEPTH_DEF) send_request(REQ_PUSH_BACK, $urandom_range(1, 1000), '0);
		send_request(REQ_PUSH_BACK, 32'd99, '0);
		write_capacity(5'd3);
		send_request(REQ_PUSH_FRONT, 32'd42, '0);
		repeat (DEPTH_DEF - 3) send_request(REQ_POP_BACK, '0, '0);
		send_request(REQ_PUSH_BACK, 32'd42, '0);
		send_request(REQ_POP_FRONT, '0, '0);
		send_request(REQ_PUSH_FRONT, 32'd42, '0);
		send_request(REQ_AT, '0, 5'd2);
	endtask

	// weighted random traffic; push weight and flow rate change in stretches
	task automatic test_random_traffic(input int count);
		int                 fill_bias;
		int                 pick;
		int                 n;
		logic [REQ_W-1:0]   code;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   pos;
		fill_bias = 30;
		for (int k = 0; k < count; k++) begin
			if (k % 60 == 0) begin
				full_rate = ($urandom_range(0, 3) == 0);
				fill_bias = 15 * $urandom_range(1, 3);
			end
			n = model_entries.size();
			value = pick_value();
			pos = POS_W'((n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
				: $urandom_range(0, 31));
			pick = $urandom_range(0, fill_bias + 59);
			if (pick < fill_bias) begin
				code = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
			end else if (pick < fill_bias + 20) begin
				code = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
			end else if (pick < fill_bias + 32) begin
				// removes mostly aim at a value that is held
				code = REQ_REMOVE;
				if (n > 0 && $urandom_range(0, 4) != 0)
					value = model_entries[$urandom_range(0, n - 1)];
			end else if (pick < fill_bias + 50) begin
				code = REQ_W'($urandom_range(REQ_FRONT, REQ_AT));
			end else if (pick < fill_bias + 56) begin
				code = REQ_REVERSE;
			end else if (pick < fill_bias + 58) begin
				code = REQ_CLEAR;
			end else begin
				code = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
			end
			send_request(code, value, pos);
		end
		full_rate = 1'b0;
	endtask

	// main sequence
	initial begin
		logic [CAP_W-1:0] limits[8];
		limits = '{5'd16, 5'd1, 5'd2, 5'd5, 5'd31, 5'd17, 5'd8, 5'd0};
		mismatch_count = 0;
		full_rate = 1'b0;
		cap_limit = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_PUSH_BACK;
		req_bus.item_value = '0;
		req_bus.position = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_requests();
		test_basic_ops();
		test_limit_below_count();
		foreach (limits[i]) begin
			write_capacity(limits[i]);
			test_random_traffic(240);
		end
		drain_pipeline();
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && expected_responses.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
